[hw/rtl/stack_permutation_checker_core_defines.svh]
// Assertion helpers for the siding checker, clocked on clock, held off in reset
`ifndef STACK_PERMUTATION_CHECKER_CORE_DEFINES_SVH
`define STACK_PERMUTATION_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication
`define SPC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spc: same-cycle check failed");

// Next-cycle implication
`define SPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spc: next-cycle check failed");

`endif

[hw/rtl/spc_pkg.sv]
package spc_pkg;

   // Largest train the siding is sized for
   localparam int MAX_CARS = 1024;

   // Width of the car field and the length register
   localparam int CAR_W = 11;

   // Siding address width
   localparam int ADDR_W = $clog2(MAX_CARS);

   // Counters must hold next_arrival up to MAX_CARS + 1 and any car number
   localparam int CNT_RAW_W = $clog2(MAX_CARS + 2);
   localparam int CNT_W = (CAR_W > CNT_RAW_W) ? CAR_W : CNT_RAW_W;

   // Register map: one register, selected by paddr bit 2
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_TRAIN_LENGTH = 1'b0;

   // Siding memory access request
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CNT_W-1:0]  wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   // Controller status
   typedef struct packed {
      logic             busy;
      logic [CNT_W-1:0] depth;
   } ctrl_status_type;

endpackage

[hw/rtl/spc_siding_ram.sv]
module spc_siding_ram (
   input  logic                        clock,
   input  spc_pkg::ram_req_type        ram_req,
   output logic [spc_pkg::CNT_W-1:0]   ram_rdata
);
   import spc_pkg::*;

   logic [CNT_W-1:0] mem [MAX_CARS];
   logic [CNT_W-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[ram_req.waddr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         rdata_ff <= mem[ram_req.raddr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

[hw/rtl/spc_csr.sv]
module spc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [spc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output logic [spc_pkg::CAR_W-1:0]      train_length
);
   import spc_pkg::*;

   logic [CAR_W-1:0] train_length_ff;
   logic [CAR_W-1:0] train_length_in;
   logic             wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == REG_TRAIN_LENGTH);

   always_comb begin
      train_length_in = train_length_ff;
      if (wr_hit) begin
         train_length_in = csr_pwdata[CAR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         train_length_ff <= CAR_W'(1);
      end else begin
         train_length_ff <= train_length_in;
      end
   end

   // Read-back; unmapped addresses read as zero
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == REG_TRAIN_LENGTH) begin
         csr_prdata = 32'(train_length_ff);
      end
   end

   assign train_length = train_length_ff;

endmodule

[hw/rtl/spc_ctrl.sv]
module spc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [spc_pkg::CAR_W-1:0]     req_car,
   output logic                          req_ready,
   output logic                          rsp_valid,
   output logic                          rsp_possible,
   input  logic                          rsp_ready,
   input  logic [spc_pkg::CAR_W-1:0]     train_length,
   output spc_pkg::ram_req_type          ram_req,
   input  logic [spc_pkg::CNT_W-1:0]     ram_rdata,
   output spc_pkg::ctrl_status_type      status
);
   import spc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_CHECK
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] car_ff, car_in;
   logic [CNT_W-1:0] next_arrival_ff, next_arrival_in;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0] position_ff, position_in;
   logic             failed_ff, failed_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_possible_ff, rsp_possible_in;

   logic [CNT_W-1:0] len_x;
   logic [CNT_W-1:0] n_eff;
   logic [CNT_W-1:0] car_x;
   logic [CNT_W-1:0] depth_dec;
   logic             last;
   logic             accept;
   logic             finish;
   logic             finish_fail;

   // Effective train length, clamped to 1..MAX_CARS
   always_comb begin
      len_x = CNT_W'(train_length);
      if (len_x == '0) begin
         n_eff = CNT_W'(1);
      end else if (len_x > CNT_W'(MAX_CARS)) begin
         n_eff = CNT_W'(MAX_CARS);
      end else begin
         n_eff = len_x;
      end
   end

   assign car_x     = CNT_W'(req_car);
   assign depth_dec = depth_ff - CNT_W'(1);
   assign last      = (position_ff + CNT_W'(1)) >= n_eff;

   // A train's last item waits until the verdict register is free
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready || !last);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in        = state_ff;
      car_in          = car_ff;
      next_arrival_in = next_arrival_ff;
      depth_in        = depth_ff;
      position_in     = position_ff;
      failed_in       = failed_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_possible_in = rsp_possible_ff;
      finish          = 1'b0;
      finish_fail     = failed_ff;
      ram_req         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               car_in = car_x;
               if (failed_ff) begin
                  finish = 1'b1;
               end else if (car_x == '0 || car_x > n_eff) begin
                  finish      = 1'b1;
                  finish_fail = 1'b1;
               end else if (next_arrival_ff <= car_x) begin
                  state_in = ST_PUSH;
               end else if (depth_ff == '0) begin
                  finish      = 1'b1;
                  finish_fail = 1'b1;
               end else begin
                  // wanted car is already parked: fetch the top
                  ram_req.re    = 1'b1;
                  ram_req.raddr = depth_dec[ADDR_W-1:0];
                  state_in      = ST_CHECK;
               end
            end
         end
         ST_PUSH: begin
            // park arrivals below the wanted car, one a cycle
            if (next_arrival_ff < car_ff) begin
               ram_req.we      = 1'b1;
               ram_req.waddr   = depth_ff[ADDR_W-1:0];
               ram_req.wdata   = next_arrival_ff;
               depth_in        = depth_ff + CNT_W'(1);
               next_arrival_in = next_arrival_ff + CNT_W'(1);
            end else begin
               // wanted car goes straight through: push and pop cancel
               next_arrival_in = car_ff + CNT_W'(1);
               finish          = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (ram_rdata == car_ff) begin
               depth_in = depth_dec;
            end else begin
               finish_fail = 1'b1;
            end
            finish   = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Position advance, verdict and train clear
      if (finish) begin
         if (last) begin
            rsp_valid_in    = 1'b1;
            rsp_possible_in = !finish_fail;
            next_arrival_in = CNT_W'(1);
            depth_in        = '0;
            position_in     = '0;
            failed_in       = 1'b0;
         end else begin
            position_in = position_ff + CNT_W'(1);
            failed_in   = finish_fail;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         next_arrival_ff <= CNT_W'(1);
         depth_ff        <= '0;
         position_ff     <= '0;
         failed_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         next_arrival_ff <= next_arrival_in;
         depth_ff        <= depth_in;
         position_ff     <= position_in;
         failed_ff       <= failed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      car_ff          <= car_in;
      rsp_possible_ff <= rsp_possible_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_possible = rsp_possible_ff;
   assign status.busy  = (state_ff != ST_IDLE);
   assign status.depth = depth_ff;

endmodule

[hw/rtl/stack_permutation_checker_core.sv]
// Steps: an out-of-range car or a failed train finishes in ST_IDLE; when the wanted
//   car is read back from the siding memory, the top is read in ST_IDLE and checked in ST_CHECK;
//   when cars are parked, ST_PUSH parks them at one siding write a cycle. A new car is taken
//   only in ST_IDLE, so not before the last one has finished.
// The verdict is registered and shows the cycle after the train's last item finishes.
// Reset (synchronous): train state cleared, train_length set to 1; siding memory is
//   left as is, with no clearing pass.
`include "stack_permutation_checker_core_defines.svh"

module stack_permutation_checker_core (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: [10:0] car, [15:11] zero
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,
   // rsp_tdata: [0] possible, [7:1] zero
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [spc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import spc_pkg::*;

   logic [CAR_W-1:0] train_length;
   ram_req_type      ram_req;
   logic [CNT_W-1:0] ram_rdata;
   ctrl_status_type  status;
   logic             rsp_possible;

   spc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .train_length (train_length)
   );

   spc_siding_ram u_ram (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   spc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_car      (req_tdata[CAR_W-1:0]),
      .req_ready    (req_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_possible (rsp_possible),
      .rsp_ready    (rsp_tready),
      .train_length (train_length),
      .ram_req      (ram_req),
      .ram_rdata    (ram_rdata),
      .status       (status)
   );

   assign rsp_tdata = {7'd0, rsp_possible};

   // Items are taken only between sequencer runs
   `SPC_ASSERT_SAME(a_ready_only_idle, req_tready, !status.busy)
   // Siding is never written and read in one cycle
   `SPC_ASSERT_SAME(a_no_rw_overlap, ram_req.we, !ram_req.re)
   // A park never goes past the siding's end
   `SPC_ASSERT_SAME(a_push_in_range, ram_req.we, status.depth < CNT_W'(MAX_CARS))
   // A top read always leads to a check cycle
   `SPC_ASSERT_NEXT(a_read_then_busy, ram_req.re, status.busy)

endmodule
